### rtl/core/rlfu_pkg.sv
package rlfu_pkg;

    localparam int TEMP_ENTRIES   = 10;
    localparam int GLOBAL_ENTRIES = 8;
    localparam int PARAM_ENTRIES  = 4;
    localparam int KEY_BITS       = 16;
    localparam int COUNT_BITS     = 16;

    localparam int FUNC_W  = 4;
    localparam int SLOT_W  = 4;
    localparam int MAX_ENTRIES = (TEMP_ENTRIES > GLOBAL_ENTRIES) ? TEMP_ENTRIES : GLOBAL_ENTRIES;
    localparam int IDX_W   = $clog2(MAX_ENTRIES + 1);
    localparam int TIDX_W  = $clog2(TEMP_ENTRIES);
    localparam int GIDX_W  = $clog2(GLOBAL_ENTRIES);
    localparam int TFILL_W = $clog2(TEMP_ENTRIES + 1);
    localparam int GFILL_W = $clog2(GLOBAL_ENTRIES + 1);
    localparam int PFILL_W = $clog2(PARAM_ENTRIES + 1);

    typedef enum logic [FUNC_W-1:0] {
        F_LOOKUP      = 4'd0,
        F_ALLOC_NAMED = 4'd1,
        F_ALLOC_ANON  = 4'd2,
        F_ALLOC_PARAM = 4'd3,
        F_REL_TEMP    = 4'd4,
        F_REL_GLOB    = 4'd5,
        F_CLR_TEMP    = 4'd6,
        F_CLR_GLOB    = 4'd7,
        F_CLR_PARAM   = 4'd8,
        F_INV_TEMP    = 4'd9,
        F_MARK_DIRTY  = 4'd10
    } t_func;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_T,
        S_SCAN_G,
        S_VICT_T,
        S_VICT_G,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic                pool;
        logic [KEY_BITS-1:0] key;
        logic [SLOT_W-1:0]   slot;
    } t_in;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_out;
        logic              status;
    } t_out;

    typedef struct packed {
        logic [KEY_BITS-1:0]   key;
        logic                  named;
        logic                  valid;
        logic [COUNT_BITS-1:0] count;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic less;
    } t_scan;

endpackage

### rtl/core/rlfu_scan_unit.sv
module rlfu_scan_unit (
    input  rlfu_pkg::t_entry                  i_entry,
    input  logic [rlfu_pkg::KEY_BITS-1:0]     i_key,
    input  logic [rlfu_pkg::COUNT_BITS-1:0]   i_least,
    output rlfu_pkg::t_scan                   o_scan
);

    assign o_scan.hit  = i_entry.named && (i_entry.key == i_key);
    assign o_scan.less = (i_entry.count < i_least);

endmodule

### rtl/core/register_pool_lfu_table.sv
// non-scan operations pass through the EXEC and DONE states before the result is registered
// lookup also compares the pool's entries in turn, up to the pool's fill count, and stops at a hit
// full-pool alloc adds a victim search over the temporary or the global pool
// one shared compare unit walks the entries, so a new item is taken only once the last result is loaded
// reset: synchronous active-low, empties all pools and drops any pending result
module register_pool_lfu_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rlfu_pkg::t_in    i_in,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rlfu_pkg::t_out   o_out
);

    localparam int TE = rlfu_pkg::TEMP_ENTRIES;
    localparam int GE = rlfu_pkg::GLOBAL_ENTRIES;
    localparam int KB = rlfu_pkg::KEY_BITS;
    localparam int CB = rlfu_pkg::COUNT_BITS;
    localparam int IW = rlfu_pkg::IDX_W;
    localparam int TW = rlfu_pkg::TIDX_W;
    localparam int GW = rlfu_pkg::GIDX_W;
    localparam int SW = rlfu_pkg::SLOT_W;

    // entry storage
    logic [KB-1:0] r_t_key   [TE];
    logic          r_t_named [TE];
    logic          r_t_valid [TE];
    logic [KB-1:0] r_g_key   [GE];
    logic          r_g_named [GE];
    logic [CB-1:0] r_g_cnt   [GE];

    rlfu_pkg::t_state r_state, n_state;
    rlfu_pkg::t_in    r_cmd;
    logic [IW-1:0]    r_idx, n_idx;
    logic [IW-1:0]    r_best, n_best;
    logic [CB-1:0]    r_least, n_least;
    logic [SW-1:0]    r_res, n_res;
    logic             r_st, n_st;
    logic [rlfu_pkg::TFILL_W-1:0] r_tfill, n_tfill;
    logic [rlfu_pkg::GFILL_W-1:0] r_gfill, n_gfill;
    logic [rlfu_pkg::PFILL_W-1:0] r_pfill, n_pfill;
    logic             r_out_valid;
    rlfu_pkg::t_out   r_out;

    logic          t_we, t_rel, t_inv;
    logic [TW-1:0] t_wa;
    logic [KB-1:0] t_wkey;
    logic          t_wnamed;
    logic          g_we, g_rel, g_bump;
    logic [GW-1:0] g_wa;
    logic [CB-1:0] g_bump_val;

    logic             accept, out_load, anon;
    logic [TW-1:0]    tidx;
    logic [GW-1:0]    gidx;
    logic [IW-1:0]    idx_nxt;
    logic [TW-1:0]    t_pick;
    logic [GW-1:0]    g_pick;
    rlfu_pkg::t_entry entry;
    rlfu_pkg::t_scan  scan;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == rlfu_pkg::S_IDLE);
    assign out_load   = (r_state == rlfu_pkg::S_DONE) && (!r_out_valid || i_out_ready);
    assign anon       = (r_cmd.func == rlfu_pkg::F_ALLOC_ANON);
    assign tidx       = r_idx[TW-1:0];
    assign gidx       = r_idx[GW-1:0];
    assign idx_nxt    = r_idx + IW'(1);
    assign g_bump_val = (r_g_cnt[gidx] == {CB{1'b1}}) ? r_g_cnt[gidx] : r_g_cnt[gidx] + CB'(1);

    always_comb begin
        if (r_state == rlfu_pkg::S_SCAN_T || r_state == rlfu_pkg::S_VICT_T) begin
            entry.key   = r_t_key[tidx];
            entry.named = r_t_named[tidx];
            entry.valid = r_t_valid[tidx];
            entry.count = '0;
        end else begin
            entry.key   = r_g_key[gidx];
            entry.named = r_g_named[gidx];
            entry.valid = 1'b1;
            entry.count = r_g_cnt[gidx];
        end
    end

    rlfu_scan_unit u_scan (
        .i_entry (entry),
        .i_key   (r_cmd.key),
        .i_least (r_least),
        .o_scan  (scan)
    );

    assign t_pick = entry.valid ? r_best[TW-1:0] : tidx;
    assign g_pick = scan.less ? gidx : r_best[GW-1:0];

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_best   = r_best;
        n_least  = r_least;
        n_res    = r_res;
        n_st     = r_st;
        n_tfill  = r_tfill;
        n_gfill  = r_gfill;
        n_pfill  = r_pfill;
        t_we     = 1'b0;
        t_rel    = 1'b0;
        t_inv    = 1'b0;
        t_wa     = '0;
        t_wkey   = anon ? '0 : r_cmd.key;
        t_wnamed = !anon;
        g_we     = 1'b0;
        g_rel    = 1'b0;
        g_bump   = 1'b0;
        g_wa     = '0;
        unique case (r_state)
            rlfu_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = rlfu_pkg::S_EXEC;
                end
            end
            rlfu_pkg::S_EXEC: begin
                n_res   = '0;
                n_st    = 1'b0;
                n_state = rlfu_pkg::S_DONE;
                unique case (r_cmd.func)
                    rlfu_pkg::F_LOOKUP: begin
                        n_idx = '0;
                        n_st  = 1'b1;
                        if (!r_cmd.pool && r_tfill != '0) begin
                            n_state = rlfu_pkg::S_SCAN_T;
                        end else if (r_cmd.pool && r_gfill != '0) begin
                            n_state = rlfu_pkg::S_SCAN_G;
                        end
                    end
                    rlfu_pkg::F_ALLOC_NAMED, rlfu_pkg::F_ALLOC_ANON: begin
                        if (anon || !r_cmd.pool) begin
                            if (r_tfill < rlfu_pkg::TFILL_W'(TE)) begin
                                t_we    = 1'b1;
                                t_wa    = r_tfill[TW-1:0];
                                n_res   = SW'(r_tfill);
                                n_tfill = r_tfill + rlfu_pkg::TFILL_W'(1);
                            end else begin
                                n_idx   = '0;
                                n_best  = '0;
                                n_state = rlfu_pkg::S_VICT_T;
                            end
                        end else begin
                            if (r_gfill < rlfu_pkg::GFILL_W'(GE)) begin
                                g_we    = 1'b1;
                                g_wa    = r_gfill[GW-1:0];
                                n_res   = SW'(r_gfill);
                                n_gfill = r_gfill + rlfu_pkg::GFILL_W'(1);
                            end else begin
                                n_idx   = IW'(1);
                                n_best  = '0;
                                n_least = r_g_cnt[0];
                                n_state = rlfu_pkg::S_VICT_G;
                            end
                        end
                    end
                    rlfu_pkg::F_ALLOC_PARAM: begin
                        if (r_pfill < rlfu_pkg::PFILL_W'(rlfu_pkg::PARAM_ENTRIES)) begin
                            n_res   = SW'(r_pfill);
                            n_pfill = r_pfill + rlfu_pkg::PFILL_W'(1);
                        end else begin
                            n_st = 1'b1;
                        end
                    end
                    rlfu_pkg::F_REL_TEMP: begin
                        if (32'(r_cmd.slot) < TE) begin
                            t_rel = 1'b1;
                            t_wa  = TW'(r_cmd.slot);
                            if (r_tfill != '0) begin
                                n_tfill = r_tfill - rlfu_pkg::TFILL_W'(1);
                            end
                        end else begin
                            n_st = 1'b1;
                        end
                    end
                    rlfu_pkg::F_REL_GLOB: begin
                        if (32'(r_cmd.slot) < GE) begin
                            g_rel = 1'b1;
                            g_wa  = GW'(r_cmd.slot);
                            if (r_gfill != '0) begin
                                n_gfill = r_gfill - rlfu_pkg::GFILL_W'(1);
                            end
                        end else begin
                            n_st = 1'b1;
                        end
                    end
                    rlfu_pkg::F_CLR_TEMP:   n_tfill = '0;
                    rlfu_pkg::F_CLR_GLOB:   n_gfill = '0;
                    rlfu_pkg::F_CLR_PARAM:  n_pfill = '0;
                    rlfu_pkg::F_INV_TEMP: begin
                        if (32'(r_cmd.slot) < TE) begin
                            t_inv = 1'b1;
                            t_wa  = TW'(r_cmd.slot);
                        end else begin
                            n_st = 1'b1;
                        end
                    end
                    rlfu_pkg::F_MARK_DIRTY: n_st = 1'b0;
                    default:                n_st = 1'b1;
                endcase
            end
            rlfu_pkg::S_SCAN_T: begin
                n_idx = idx_nxt;
                if (scan.hit) begin
                    n_res   = SW'(r_idx);
                    n_st    = 1'b0;
                    n_state = rlfu_pkg::S_DONE;
                end else if (idx_nxt == IW'(r_tfill)) begin
                    n_state = rlfu_pkg::S_DONE;
                end
            end
            rlfu_pkg::S_SCAN_G: begin
                n_idx = idx_nxt;
                if (scan.hit) begin
                    g_bump  = 1'b1;
                    g_wa    = gidx;
                    n_res   = SW'(r_idx);
                    n_st    = 1'b0;
                    n_state = rlfu_pkg::S_DONE;
                end else if (idx_nxt == IW'(r_gfill)) begin
                    n_state = rlfu_pkg::S_DONE;
                end
            end
            rlfu_pkg::S_VICT_T: begin
                n_idx  = idx_nxt;
                n_best = IW'(t_pick);
                if (r_idx == IW'(TE - 1)) begin
                    t_we    = 1'b1;
                    t_wa    = t_pick;
                    n_res   = SW'(t_pick);
                    n_state = rlfu_pkg::S_DONE;
                end
            end
            rlfu_pkg::S_VICT_G: begin
                n_idx  = idx_nxt;
                n_best = IW'(g_pick);
                if (scan.less) begin
                    n_least = entry.count;
                end
                if (r_idx == IW'(GE - 1)) begin
                    g_we    = 1'b1;
                    g_wa    = g_pick;
                    n_res   = SW'(g_pick);
                    n_state = rlfu_pkg::S_DONE;
                end
            end
            rlfu_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = rlfu_pkg::S_IDLE;
                end
            end
            default: n_state = rlfu_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rlfu_pkg::S_IDLE;
            r_tfill     <= '0;
            r_gfill     <= '0;
            r_pfill     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tfill     <= n_tfill;
            r_gfill     <= n_gfill;
            r_pfill     <= n_pfill;
            r_out_valid <= out_load || (r_out_valid && !i_out_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_in;
        end
        if (out_load) begin
            r_out.slot_out <= r_res;
            r_out.status   <= r_st;
        end
        r_idx   <= n_idx;
        r_best  <= n_best;
        r_least <= n_least;
        r_res   <= n_res;
        r_st    <= n_st;
    end

    // temporary pool
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TE; i++) begin
                r_t_named[i] <= 1'b0;
                r_t_valid[i] <= 1'b0;
            end
        end else if (t_we) begin
            r_t_named[t_wa] <= t_wnamed;
            r_t_valid[t_wa] <= 1'b1;
        end else if (t_rel) begin
            r_t_named[t_wa] <= 1'b0;
            r_t_valid[t_wa] <= 1'b0;
        end else if (t_inv) begin
            r_t_valid[t_wa] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (t_we) begin
            r_t_key[t_wa] <= t_wkey;
        end
    end

    // global pool
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GE; i++) begin
                r_g_named[i] <= 1'b0;
            end
        end else if (g_we) begin
            r_g_named[g_wa] <= 1'b1;
        end else if (g_rel) begin
            r_g_named[g_wa] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_we) begin
            r_g_key[g_wa] <= r_cmd.key;
            r_g_cnt[g_wa] <= CB'(1);
        end else if (g_rel) begin
            r_g_cnt[g_wa] <= '0;
        end else if (g_bump) begin
            r_g_cnt[g_wa] <= g_bump_val;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### rtl/core/rlfu_checker.sv
module rlfu_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input rlfu_pkg::t_out   o_out
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // busy after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after input transfer");

    // failed operations report slot zero
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status |-> o_out.slot_out == '0)
        else $error("nonzero slot with failing status");

    // slot within the largest pool
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out.slot_out) < rlfu_pkg::MAX_ENTRIES)
        else $error("slot out of range");

    // reset drops any result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind register_pool_lfu_table rlfu_checker u_rlfu_checker (.*);
